>>> hdl/cfrth_pkg.sv
// Shared constants and types for the continued-fraction range and height finder.
package cfrth_pkg;

  localparam int TQ = 30;
  localparam int DW = 64;

  typedef logic [DW-1:0] word_t;

  localparam word_t TAN_SAT  = (word_t'(1) << 40) - word_t'(1);
  localparam word_t ALL_ONES = {DW{1'b1}};

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_ALPHA = 2'd1;
  localparam logic [1:0] STATUS_BAD_BETA  = 2'd2;

endpackage

>>> hdl/cfrth_div.sv
// Shared restoring divider, one quotient bit per cycle, with registered result.
module cfrth_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cfrth_pkg::word_t dividend,
  input  cfrth_pkg::word_t divisor,
  output cfrth_pkg::word_t quotient,
  output logic           done
);
  import cfrth_pkg::*;

  logic [DW:0]  rem;
  word_t        quo;
  word_t        dsr;
  logic [6:0]   cnt;
  logic [DW:0]  trial;
  logic [DW:0]  diff;

  always_comb begin
    trial = {rem[DW-1:0], quo[DW-1]};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 7'(DW);
        rem <= '0;
        quo <= dividend;
        dsr <= divisor;
      end else if (cnt != 7'd0) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          done <= 1'b1;
        end
        if (!diff[DW]) begin
          rem <= diff;
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient = quo;

endmodule

>>> hdl/cfrth_mul.sv
// Exact 64 by 64 multiplier built from four 32 by 32 partial products taken in turn.
module cfrth_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cfrth_pkg::word_t a,
  input  cfrth_pkg::word_t b,
  output logic [127:0]     product,
  output logic             done
);
  import cfrth_pkg::*;

  word_t        ra;
  word_t        rb;
  logic [2:0]   k;
  logic         run;
  logic [1:0]   pk;
  logic [63:0]  pp;
  logic [31:0]  ai;
  logic [31:0]  bj;
  logic [6:0]   sh;

  always_comb begin
    ai = k[1] ? ra[63:32] : ra[31:0];
    bj = k[0] ? rb[63:32] : rb[31:0];
    case (pk)
      2'd0:    sh = 7'd0;
      2'd3:    sh = 7'd64;
      default: sh = 7'd32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ra      <= a;
        rb      <= b;
        k       <= '0;
        run     <= 1'b1;
        product <= '0;
      end else if (run) begin
        if (k != 3'd4) begin
          pp <= 64'(ai) * 64'(bj);
          pk <= k[1:0];
          k  <= k + 3'd1;
        end else begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        if (k != 3'd0) begin
          product <= product + ({64'b0, pp} << sh);
        end
      end
    end
  end

endmodule

>>> hdl/cfrac_tangent_range_height.sv
// Top level of the range and height finder: sequencer around a shared divider and a multiplier.
// Each tangent is found by evaluating Lambert's continued fraction with one term, then two
// and so on, until two successive values differ by at most the tolerance or MAX_TERMS terms
// are used, so an angle needs up to MAX_TERMS*(MAX_TERMS+1)/2 divisions. Every division
// passes through the single shared divider, which sets the rate; far fewer divisions are
// needed when the fraction converges early. The input stalls from acceptance until the
// result has been taken; an out of range alpha goes straight to the output state.
module cfrac_tangent_range_height #(
  parameter int MAX_TERMS       = 16,
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] alpha_angle,
  input  logic [30:0] beta_angle,
  input  logic        beta_present,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] distance,
  output logic [63:0] object_height,
  output logic        height_valid,
  output logic [1:0]  status
);
  import cfrth_pkg::*;

  localparam int TW = $clog2(MAX_TERMS + 1);
  localparam int SH = TQ - ANGLE_FRAC_BITS;
  localparam logic [35:0] ALIM = 36'(14) << ANGLE_FRAC_BITS;
  localparam logic [TW-1:0] TMAX = TW'(MAX_TERMS);
  localparam logic [TW-1:0] TONE = TW'(1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_TERM  = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_CONV  = 4'd5;
  localparam logic [3:0] S_DIST  = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;
  localparam logic [3:0] S_BETA  = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_ADD   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  function automatic logic angle_ok(input logic [30:0] ang);
    logic [35:0] ten;
    ten = {2'b0, ang, 3'b0} + {4'b0, ang, 1'b0};
    return (ang != 31'd0) && (ten <= ALIM);
  endfunction

  logic [3:0]    st;
  logic [30:0]   instrument_height;
  logic [7:0]    tolerance;
  logic [30:0]   beta;
  logic          want;
  logic          phase;
  logic [30:0]   x;
  logic [30:0]   sq;
  logic [TW-1:0] ti;
  logic [TW-1:0] tj;
  word_t         cf;
  word_t         t;

  logic          div_start;
  word_t         div_num;
  word_t         div_den;
  word_t         div_q;
  logic          div_done;
  logic          mul_start;
  logic [127:0]  prod;
  logic          mul_done;

  logic [TW:0]   odd;
  word_t         term_a;
  word_t         step_num;
  word_t         diff;
  logic [64:0]   hsum;

  always_comb begin
    odd      = {tj, 1'b0} - {{TW{1'b0}}, 1'b1};
    term_a   = word_t'(odd) << TQ;
    step_num = word_t'((tj == TONE) ? x : sq) << TQ;
    diff     = (cf > t) ? (cf - t) : (t - cf);
    hsum     = {1'b0, object_height} + 65'(instrument_height);
    div_start = 1'b0;
    div_num   = step_num;
    div_den   = term_a - cf;
    if (st == S_STEP) begin
      div_start = (cf < term_a);
    end else if (st == S_DIST) begin
      div_start = (cf != '0);
      div_num   = word_t'(instrument_height) << TQ;
      div_den   = cf;
    end
    mul_start = (st == S_CONV) && phase &&
                ((diff <= word_t'(tolerance)) || (ti == TMAX));
  end

  cfrth_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  cfrth_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (cf),
    .b       (distance),
    .product (prod),
    .done    (mul_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      instrument_height <= 31'd25165824;
      tolerance         <= 8'd1;
    end else if (cfg_write) begin
      if (cfg_index == 1'b0) begin
        instrument_height <= cfg_data;
      end else begin
        tolerance <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            beta          <= beta_angle;
            want          <= beta_present;
            phase         <= 1'b0;
            distance      <= '0;
            object_height <= '0;
            height_valid  <= 1'b0;
            status        <= STATUS_OK;
            x             <= 31'(alpha_angle << SH);
            if (angle_ok(alpha_angle)) begin
              st <= S_SQ;
            end else begin
              status <= STATUS_BAD_ALPHA;
              st     <= S_OUT;
            end
          end
        end
        S_SQ: begin
          sq <= 31'((62'(x) * 62'(x)) >> TQ);
          ti <= TONE;
          t  <= '0;
          st <= S_TERM;
        end
        S_TERM: begin
          tj <= ti;
          cf <= '0;
          st <= S_STEP;
        end
        S_STEP: begin
          if (cf >= term_a) begin
            cf <= TAN_SAT;
            if (tj == TONE) begin
              st <= S_CONV;
            end else begin
              tj <= tj - TONE;
            end
          end else begin
            st <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cf <= div_q;
            if (tj == TONE) begin
              st <= S_CONV;
            end else begin
              tj <= tj - TONE;
              st <= S_STEP;
            end
          end
        end
        S_CONV: begin
          if ((diff <= word_t'(tolerance)) || (ti == TMAX)) begin
            st <= phase ? S_MUL : S_DIST;
          end else begin
            t  <= cf;
            ti <= ti + TONE;
            st <= S_TERM;
          end
        end
        S_DIST: begin
          if (cf == '0) begin
            distance <= ALL_ONES;
            st       <= S_BETA;
          end else begin
            st <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            distance <= div_q;
            st       <= S_BETA;
          end
        end
        S_BETA: begin
          if (!want) begin
            st <= S_OUT;
          end else if (!angle_ok(beta)) begin
            status <= STATUS_BAD_BETA;
            st     <= S_OUT;
          end else begin
            x     <= 31'(beta << SH);
            phase <= 1'b1;
            st    <= S_SQ;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            if (prod[127:94] != '0) begin
              object_height <= ALL_ONES;
            end else begin
              object_height <= prod[93:30];
            end
            st <= S_ADD;
          end
        end
        S_ADD: begin
          object_height <= hsum[64] ? ALL_ONES : hsum[63:0];
          height_valid  <= 1'b1;
          st            <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (st != S_IDLE);
  assign out_valid = (st == S_OUT);

endmodule

>>> tb/cfrac_tangent_range_height_tb.sv
// Self-checking testbench for the continued-fraction range and height finder.
`timescale 1ns / 100ps

module cfrac_tangent_range_height_tb;
  import cfrth_pkg::*;

  localparam int NTERMS = 16;
  localparam int AFRAC  = 28;
  localparam logic CFG_HEIGHT    = 1'b0;
  localparam logic CFG_TOLERANCE = 1'b1;
  localparam logic [30:0] ANGLE_LIMIT = 31'd375809638;

  typedef struct packed {
    word_t      dist_out;
    word_t      hgt;
    logic       hvalid;
    logic [1:0] stat;
  } range_t;

  typedef struct {
    logic [30:0] alpha;
    logic [30:0] beta;
    logic        bp;
    logic        typed;
    range_t      res;
  } row_t;

  logic        clk, rst;
  logic        cfg_write, cfg_index;
  logic [30:0] cfg_data;
  logic        in_valid, in_stall;
  logic [30:0] alpha_angle, beta_angle;
  logic        beta_present;
  logic        out_valid, out_stall;
  logic [63:0] distance, object_height;
  logic        height_valid;
  logic [1:0]  status;

  logic [30:0] height_reg;
  logic [7:0]  tol_reg;
  range_t      pending_ranges[$];
  row_t        directed[$];
  int          mismatches, results_seen, items_sent, ok_count, bad_beta_count;
  bit          stall_mode;

  cfrac_tangent_range_height u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd400_000_000);
    $display("FAILURE");
    $finish;
  end

  function automatic bit angle_in_range(logic [30:0] a);
    return a != 0 && 64'(a) * 10 <= (64'd14 << AFRAC);
  endfunction

  function automatic word_t lambert_tan(logic [30:0] ang);
    word_t x, sq, t, prev, d, cf, a, num;
    x  = word_t'(ang) << (TQ - AFRAC);
    sq = (x * x) >> TQ;
    t  = '0;
    for (int i = 1; i <= NTERMS; i++) begin
      prev = t;
      cf = '0;
      for (int j = i; j > 0; j--) begin
        a = word_t'(2 * j - 1) << TQ;
        if (cf >= a) begin
          cf = TAN_SAT;
        end else begin
          num = (j == 1 ? x : sq) << TQ;
          cf = num / (a - cf);
        end
      end
      t = cf;
      d = t > prev ? t - prev : prev - t;
      if (d <= word_t'(tol_reg)) break;
    end
    return t;
  endfunction

  function automatic range_t range_height(logic [30:0] al, logic [30:0] be, logic bp);
    range_t r;
    word_t ta;
    logic [127:0] prod;
    logic [64:0] total;
    r = '0;
    if (!angle_in_range(al)) begin
      r.stat = STATUS_BAD_ALPHA;
    end else begin
      ta = lambert_tan(al);
      r.dist_out = ta == 0 ? ALL_ONES : (word_t'(height_reg) << TQ) / ta;
      r.stat = STATUS_OK;
      if (bp) begin
        if (!angle_in_range(be)) begin
          r.stat = STATUS_BAD_BETA;
        end else begin
          prod = (128'(lambert_tan(be)) * 128'(r.dist_out)) >> TQ;
          total = (prod[127:64] != 0) ? {1'b0, ALL_ONES} : {1'b0, prod[63:0]};
          total = total + 65'(height_reg);
          r.hgt = total[64] ? ALL_ONES : total[63:0];
          r.hvalid = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic add_row(logic [30:0] al, logic [30:0] be, logic bp, logic typed,
                         range_t res);
    row_t row;
    row.alpha = al;
    row.beta  = be;
    row.bp    = bp;
    row.typed = typed;
    row.res   = res;
    directed.push_back(row);
  endtask

  task automatic write_reg(logic idx, logic [30:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic drain;
    wait (pending_ranges.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_item(logic [30:0] al, logic [30:0] be, logic bp, logic typed,
                           range_t res);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    alpha_angle  = al;
    beta_angle   = be;
    beta_present = bp;
    do @(posedge clk); while (in_stall);
    pending_ranges.push_back(typed ? res : range_height(al, be, bp));
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [30:0] random_valid_angle();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(1, 1000));
      1: return ANGLE_LIMIT - 31'($urandom_range(0, 1000));
      default: return 31'($urandom_range(1, ANGLE_LIMIT));
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [30:0] al, be;
    for (int n = 0; n < count; n++) begin
      al = ($urandom_range(0, 9) == 0) ? 31'($urandom) : random_valid_angle();
      be = ($urandom_range(0, 9) == 0) ? 31'($urandom) : random_valid_angle();
      send_item(al, be, 1'($urandom), 1'b0, '0);
    end
    in_valid = 1'b0;
  endtask

  initial begin
    range_t bad_alpha;
    bad_alpha = '{dist_out: '0, hgt: '0, hvalid: 1'b0, stat: STATUS_BAD_ALPHA};
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_valid = 1'b0; alpha_angle = '0; beta_angle = '0; beta_present = 1'b0;
    height_reg = 31'd25165824;
    tol_reg = 8'd1;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    add_row(31'd0, 31'd0, 1'b1, 1'b1, bad_alpha);
    add_row(31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b1, bad_alpha);
    add_row(ANGLE_LIMIT + 31'd1, 31'd1000, 1'b0, 1'b1, bad_alpha);
    add_row(ANGLE_LIMIT, ANGLE_LIMIT, 1'b1, 1'b0, '0);
    add_row(31'd1, 31'd1, 1'b1, 1'b0, '0);
    add_row(31'd1, ANGLE_LIMIT, 1'b1, 1'b0, '0);
    add_row(ANGLE_LIMIT, 31'd1, 1'b1, 1'b0, '0);
    add_row(31'd140000000, 31'd0, 1'b1, 1'b0, '0);
    add_row(31'd140000000, ANGLE_LIMIT + 31'd1, 1'b1, 1'b0, '0);
    add_row(31'd140000000, 31'h7FFFFFFF, 1'b1, 1'b0, '0);
    add_row(31'd140000000, 31'd200000000, 1'b0, 1'b0, '0);
    add_row(31'd268435456, 31'd268435456, 1'b1, 1'b0, '0);
    foreach (directed[k])
      send_item(directed[k].alpha, directed[k].beta, directed[k].bp,
                directed[k].typed, directed[k].res);
    in_valid = 1'b0;
    drain();

    add_row(31'd0, 31'd0, 1'b0, 1'b0, '0);
    height_reg = 31'd1677721600; tol_reg = 8'd0;
    write_reg(CFG_HEIGHT, height_reg);
    write_reg(CFG_TOLERANCE, 31'h7FFFFF00 | 31'(tol_reg));
    send_item(31'd1, ANGLE_LIMIT, 1'b1, 1'b0, '0);
    send_item(ANGLE_LIMIT, ANGLE_LIMIT, 1'b1, 1'b0, '0);
    random_phase(30);
    drain();

    height_reg = 31'd1; tol_reg = 8'd255;
    write_reg(CFG_HEIGHT, height_reg);
    write_reg(CFG_TOLERANCE, 31'(tol_reg));
    random_phase(30);
    drain();

    height_reg = 31'h7FFFFFFF; tol_reg = 8'($urandom_range(0, 255));
    write_reg(CFG_HEIGHT, height_reg);
    write_reg(CFG_TOLERANCE, 31'(tol_reg));
    send_item(31'd1, 31'd1, 1'b1, 1'b0, '0);
    random_phase(25);
    drain();

    height_reg = 31'd0; tol_reg = 8'd1;
    write_reg(CFG_HEIGHT, height_reg);
    write_reg(CFG_TOLERANCE, 31'(tol_reg));
    random_phase(10);
    drain();

    height_reg = 31'($urandom_range(1, 1677721600)); tol_reg = 8'($urandom_range(0, 255));
    write_reg(CFG_HEIGHT, height_reg);
    write_reg(CFG_TOLERANCE, 31'(tol_reg));
    random_phase(30);

    wait (pending_ranges.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d transactions over six register settings, %0d results checked.",
             items_sent, results_seen);
    $display("Results with status ok: %0d, with beta out of range: %0d, mismatches: %0d.",
             ok_count, bad_beta_count, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The receiver alternates between quiet stretches and heavy random stalling.
  always @(negedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      out_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
    end
  end

  always @(posedge clk) begin
    range_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{dist_out: distance, hgt: object_height, hvalid: height_valid, stat: status};
      results_seen++;
      if (pending_ranges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: %p", got);
      end else begin
        want = pending_ranges.pop_front();
        if (want.stat == STATUS_OK) ok_count++;
        if (want.stat == STATUS_BAD_BETA) bad_beta_count++;
        if (got.dist_out !== want.dist_out || got.hgt !== want.hgt ||
            got.hvalid !== want.hvalid || got.stat !== want.stat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected dist %h hgt %h hv %b st %0d, got %h %h %b %0d",
                     want.dist_out, want.hgt, want.hvalid, want.stat,
                     got.dist_out, got.hgt, got.hvalid, got.stat);
        end
      end
    end
  end

endmodule
